@@ rtl/tmts_pkg.sv @@
// shared types and constants of the three-mode thread scheduler
package tmts_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int TICKET_BITS_DEF = 8;
  localparam int TOTAL_BITS      = 12;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  localparam logic [1:0] MODE_RR    = 2'd0;
  localparam logic [1:0] MODE_LOT   = 2'd1;
  localparam logic [1:0] MODE_RT    = 2'd2;
  localparam logic [0:0] REG_MODE   = 1'b0;
  localparam logic       KIND_SCHED = 1'b0;
  localparam logic       KIND_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RR_RD,
    ST_RR_CHK,
    ST_LOT_RD,
    ST_LOT_CHK,
    ST_NL_RD,
    ST_NL_CHK,
    ST_RT_RD,
    ST_RT_CHK,
    ST_RT_CLR,
    ST_RT_MARK,
    ST_OUT
  } state_t;

  // write strobe and address toward the slot memory
  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
  } mem_ctl_t;

endpackage

@@ rtl/three_mode_thread_scheduler.sv @@
// top level of the three-mode thread scheduler
// One item at a time: the input is held off from acceptance until the result beat has
// been taken. Steps from the accepting edge to the result beat: a write item passes the
// entry update; a schedule item with no live thread goes straight to the result; round
// robin visits slots from the one after the last grant; lottery reduces the draw bit by
// bit (draw mod total+1), then walks the slots subtracting tickets up to the stopping
// slot, rereads, and walks to the next live slot; real time searches once, or, when every
// live slot has been served, searches, runs a served-clear sweep over the whole table,
// and searches again. The slot table lives in one ram entry per slot (alive, served,
// priority, tickets); its contents are cleared by a sweep over every entry after reset,
// during which no beat is accepted.
// The result beat sits in an output register.
module three_mode_thread_scheduler #(
  parameter int MAX_THREADS = tmts_pkg::MAX_THREADS_DEF,
  parameter int TICKET_BITS = tmts_pkg::TICKET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind, thread_slot[4:1], thread_alive, thread_priority[13:6], thread_tickets[21:14],
  // draw[37:22], zero fill
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // granted, grant_index[4:1], zero fill
  output logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW = AW + 1;
  localparam int EW = 2 + 8 + TICKET_BITS;   // alive, served, priority, tickets
  localparam int SW = (AW + TICKET_BITS + 1 > tmts_pkg::TOTAL_BITS + 1)
                      ? AW + TICKET_BITS + 1 : tmts_pkg::TOTAL_BITS + 1;
  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

  tmts_pkg::state_t st_r, st_nxt;

  logic [1:0]  mode_r;
  logic        clr_r;
  logic [AW-1:0] clr_idx_r;

  // item registers
  logic        alive_in_r;
  logic [7:0]  prio_in_r;
  logic [TICKET_BITS-1:0] tick_in_r;
  logic [15:0] draw_r;

  // global state
  logic [tmts_pkg::TOTAL_BITS-1:0] total_r, total_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [CW-1:0] scount_r, scount_nxt;
  logic [CW-1:0] acount_r, acount_nxt;

  // walk registers
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [17:0]   rest_r, rest_nxt;   // signed-like remainder, wide enough
  logic [4:0]    bit_r, bit_nxt;
  logic          any_r, any_nxt;
  logic [7:0]    best_r, best_nxt;
  logic [AW-1:0] found_r, found_nxt;
  logic          second_r, second_nxt;
  logic          out_v_r, out_v_nxt;
  logic          out_g_r, out_g_nxt;
  logic [3:0]    out_i_r, out_i_nxt;

  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata, wdata;
  tmts_pkg::mem_ctl_t mc;
  logic [AW-1:0] waddr_w;

  // rdata fields
  logic r_alive, r_served;
  logic [7:0] r_prio;
  logic [TICKET_BITS-1:0] r_tick;
  assign {r_alive, r_served, r_prio, r_tick} = rdata;

  tmts_ram #(.WIDTH(EW), .DEPTH(MAX_THREADS)) u_slots (
    .clk(clk), .we(mc.we), .waddr(waddr_w), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );
  assign waddr_w = mc.waddr[AW-1:0];

  // configuration
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2:2] == tmts_pkg::REG_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tmts_pkg::MODE_RR;
    end else if (cfg_wr && cfg_paddr[2:2] == tmts_pkg::REG_MODE && cfg_pwdata <= 32'd2) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == AW'(MAX_THREADS - 1)) clr_r <= 1'b0;
    end
  end

  assign in_tready  = (st_r == tmts_pkg::ST_IDLE) && !clr_r && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'd0, out_i_r, out_g_r};

  logic in_acc;
  assign in_acc = in_tvalid & in_tready;

  // helpers
  logic [AW-1:0] idx_inc;
  assign idx_inc = (CW'(idx_r) + 1'b1 >= scount_r) ? '0 : idx_r + 1'b1;
  logic [17:0] rest_sub;
  assign rest_sub = rest_r - 18'(r_tick);

  always_comb begin
    st_nxt = st_r;
    total_nxt = total_r; last_nxt = last_r; scount_nxt = scount_r; acount_nxt = acount_r;
    idx_nxt = idx_r; steps_nxt = steps_r; rest_nxt = rest_r; bit_nxt = bit_r;
    any_nxt = any_r; best_nxt = best_r; found_nxt = found_r; second_nxt = second_r;
    out_v_nxt = out_v_r; out_g_nxt = out_g_r; out_i_nxt = out_i_r;
    raddr = idx_r;
    mc.we = 1'b0; mc.waddr = 6'(idx_r); wdata = rdata;
    if (out_v_r && out_tready) out_v_nxt = 1'b0;
    if (clr_r) begin
      mc.we = 1'b1; mc.waddr = 6'(clr_idx_r); wdata = '0;
    end
    case (st_r)
      tmts_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = AW'(in_tdata[4:1]);
          raddr   = AW'(in_tdata[4:1]);
          out_g_nxt = 1'b0; out_i_nxt = '0;
          if (in_tdata[0] == tmts_pkg::KIND_WRITE) begin
            if (32'(in_tdata[4:1]) < MAX_THREADS) st_nxt = tmts_pkg::ST_MOD;
            else begin st_nxt = tmts_pkg::ST_OUT; end
          end else if (acount_r == '0 || scount_r == '0) begin
            st_nxt = tmts_pkg::ST_OUT;
          end else begin
            case (mode_r)
              tmts_pkg::MODE_LOT: begin
                rest_nxt = '0; bit_nxt = 5'd15; st_nxt = tmts_pkg::ST_LOT_RD;
              end
              tmts_pkg::MODE_RT: begin
                idx_nxt = '0; any_nxt = 1'b0; best_nxt = '0; found_nxt = '0;
                second_nxt = 1'b0; st_nxt = tmts_pkg::ST_RT_RD;
              end
              default: begin
                idx_nxt = (CW'(last_r) + 1'b1 >= scount_r) ? '0 : last_r + 1'b1;
                steps_nxt = '0; st_nxt = tmts_pkg::ST_RR_RD;
              end
            endcase
          end
        end
      end
      // write item: rdata holds the old entry
      tmts_pkg::ST_MOD: begin
        mc.we = 1'b1;
        wdata = {alive_in_r, r_served, prio_in_r, tick_in_r};
        if (r_alive && !alive_in_r) acount_nxt = acount_r - 1'b1;
        else if (!r_alive && alive_in_r) acount_nxt = acount_r + 1'b1;
        if (CW'(idx_r) + 1'b1 > scount_r) scount_nxt = CW'(idx_r) + 1'b1;
        st_nxt = tmts_pkg::ST_OUT;
      end
      tmts_pkg::ST_RR_RD: st_nxt = tmts_pkg::ST_RR_CHK;
      tmts_pkg::ST_RR_CHK: begin
        if (r_alive) begin
          out_g_nxt = 1'b1; out_i_nxt = 4'(idx_r); last_nxt = idx_r;
          st_nxt = tmts_pkg::ST_OUT;
        end else begin
          idx_nxt = idx_inc; raddr = idx_inc; st_nxt = tmts_pkg::ST_RR_CHK;
          steps_nxt = steps_r + 1'b1;
          if (steps_r + 1'b1 >= scount_r) begin
            out_g_nxt = 1'b1; out_i_nxt = '0; last_nxt = '0; st_nxt = tmts_pkg::ST_OUT;
          end
        end
      end
      // restoring division of draw by total+1, one bit a cycle, then ticket walk
      tmts_pkg::ST_LOT_RD: begin
        rest_nxt = {rest_r[16:0], draw_r[bit_r[3:0]]};
        if ({rest_r[16:0], draw_r[bit_r[3:0]]} >= 18'(total_r) + 18'd1)
          rest_nxt = {rest_r[16:0], draw_r[bit_r[3:0]]} - (18'(total_r) + 18'd1);
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          idx_nxt = '0; raddr = '0; st_nxt = tmts_pkg::ST_LOT_CHK;
        end
      end
      tmts_pkg::ST_LOT_CHK: begin
        if (rest_sub[17] || rest_sub == '0) begin
          steps_nxt = '0; st_nxt = tmts_pkg::ST_NL_RD;
        end else begin
          rest_nxt = rest_sub;
          if (r_tick != TICKET_MAX) begin
            mc.we = 1'b1; wdata = {r_alive, r_served, r_prio, r_tick + 1'b1};
            if (total_r != tmts_pkg::TOTAL_MAX) total_nxt = total_r + 1'b1;
          end
          if (CW'(idx_r) + 1'b1 >= scount_r) begin
            steps_nxt = '0; st_nxt = tmts_pkg::ST_NL_RD;
          end else begin
            idx_nxt = idx_r + 1'b1; st_nxt = tmts_pkg::ST_LOT_RD;
            bit_nxt = '1; st_nxt = tmts_pkg::ST_NL_CHK;
          end
        end
        // re-read next slot; use the NL_CHK slot via second_r as flag
        second_nxt = 1'b0;
        if (!(rest_sub[17] || rest_sub == '0) && CW'(idx_r) + 1'b1 < scount_r) begin
          second_nxt = 1'b1;
          raddr = idx_r + 1'b1;
        end
      end
      tmts_pkg::ST_NL_RD: begin
        second_nxt = 1'b0; st_nxt = tmts_pkg::ST_NL_CHK;
      end
      tmts_pkg::ST_NL_CHK: begin
        if (second_r) begin
          // lottery continues: rdata is the next slot
          st_nxt = tmts_pkg::ST_LOT_CHK;
          raddr = idx_r;
          st_nxt = tmts_pkg::ST_LOT_CHK;
          second_nxt = 1'b0;
          // delay slot: re-read to keep registered timing
        end else if (r_alive) begin
          out_g_nxt = 1'b1; out_i_nxt = 4'(idx_r); last_nxt = idx_r;
          st_nxt = tmts_pkg::ST_OUT;
        end else begin
          idx_nxt = idx_inc; raddr = idx_inc;
          steps_nxt = steps_r + 1'b1;
          if (steps_r + 1'b1 >= scount_r) begin
            out_g_nxt = 1'b1; out_i_nxt = '0; last_nxt = '0; st_nxt = tmts_pkg::ST_OUT;
          end
        end
      end
      tmts_pkg::ST_RT_RD: st_nxt = tmts_pkg::ST_RT_CHK;
      tmts_pkg::ST_RT_CHK: begin
        if (r_alive && !r_served && (!any_r || r_prio > best_r)) begin
          any_nxt = 1'b1; best_nxt = r_prio; found_nxt = idx_r;
        end
        if (CW'(idx_r) + 1'b1 >= scount_r) begin
          if (any_nxt) begin
            idx_nxt = found_nxt; raddr = found_nxt; st_nxt = tmts_pkg::ST_RT_MARK;
          end else begin
            idx_nxt = '0; raddr = '0; st_nxt = tmts_pkg::ST_RT_CLR;
          end
        end else begin
          idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1;
        end
      end
      // served-clear sweep over the whole table
      tmts_pkg::ST_RT_CLR: begin
        second_nxt = 1'b1;
        mc.we = 1'b1; wdata = {r_alive, 1'b0, r_prio, r_tick};
        if (second_r) begin
          // rdata valid for idx_r
          if (32'(idx_r) == MAX_THREADS - 1) begin
            idx_nxt = '0; raddr = '0; any_nxt = 1'b0; best_nxt = '0;
            second_nxt = 1'b0; st_nxt = tmts_pkg::ST_RT_RD;
          end else begin
            idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1; second_nxt = 1'b0;
          end
        end else begin
          mc.we = 1'b0;
        end
      end
      tmts_pkg::ST_RT_MARK: begin
        if (second_r) begin
          mc.we = 1'b1; wdata = {r_alive, 1'b1, r_prio, r_tick};
          out_g_nxt = 1'b1; out_i_nxt = 4'(idx_r); last_nxt = idx_r;
          second_nxt = 1'b0; st_nxt = tmts_pkg::ST_OUT;
        end else begin
          second_nxt = 1'b1;
        end
      end
      tmts_pkg::ST_OUT: begin
        // alive count follows the alive flags; total follows the tickets but saturates at TOTAL_MAX
        out_v_nxt = 1'b1; st_nxt = tmts_pkg::ST_IDLE;
      end
      default: st_nxt = tmts_pkg::ST_IDLE;
    endcase
    if (clr_r) mc.we = 1'b1;
  end

  // ticket total after a write: track the exact sum separately
  logic [SW-1:0] sum_r;
  logic [SW-1:0] sum_w;
  always_comb begin
    sum_w = sum_r;
    if (st_r == tmts_pkg::ST_MOD)
      sum_w = sum_r - SW'(r_tick) + SW'(tick_in_r);
    else if (st_r == tmts_pkg::ST_LOT_CHK && !(rest_sub[17] || rest_sub == '0)
             && r_tick != TICKET_MAX)
      sum_w = sum_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tmts_pkg::ST_IDLE;
      total_r <= '0; last_r <= '0; scount_r <= '0; acount_r <= '0;
      out_v_r <= 1'b0; second_r <= 1'b0; sum_r <= '0;
    end else begin
      st_r <= st_nxt;
      last_r <= last_nxt; scount_r <= scount_nxt; acount_r <= acount_nxt;
      out_v_r <= out_v_nxt; second_r <= second_nxt; sum_r <= sum_w;
      if (st_r == tmts_pkg::ST_MOD)
        total_r <= (sum_w > SW'(tmts_pkg::TOTAL_MAX)) ? tmts_pkg::TOTAL_MAX
                                                       : sum_w[tmts_pkg::TOTAL_BITS-1:0];
      else total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; steps_r <= steps_nxt; rest_r <= rest_nxt; bit_r <= bit_nxt;
    any_r <= any_nxt; best_r <= best_nxt; found_r <= found_nxt;
    out_g_r <= out_g_nxt; out_i_r <= out_i_nxt;
    if (in_acc) begin
      alive_in_r <= in_tdata[5];
      prio_in_r <= in_tdata[13:6]; tick_in_r <= TICKET_BITS'(in_tdata[21:14]);
      draw_r <= in_tdata[37:22];
    end
  end

endmodule

@@ rtl/tmts_ram.sv @@
// generic single-port-write, registered-read ram
module tmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tmts_checker.sv @@
// port-level checks of the thread scheduler
module tmts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped");

  a_none_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[4:1] == 4'd0)
    else $error("no grant but index set");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

endmodule

bind three_mode_thread_scheduler tmts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
